### src/dkx_pkg.sv
// Shared types and constants for the dual-key XOR feedback cipher.
package dkx_pkg;

  localparam int FUNC_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int SLOT_W    = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_CIPHER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_A_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_B_LEN = 2'd1;

  localparam logic [CFG_W-1:0] LEN_RESET = 7'd1;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] ka;
    logic [BYTE_W-1:0] kb;
    logic              last;
  } entry_t;

endpackage

### src/dkx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dkx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/dkx_front.sv
// Front part: accepts items, loads keys, steps key positions, reads key bytes.
module dkx_front import dkx_pkg::*; #(
  parameter int KEY_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    func,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic [SLOT_W-1:0]    key_slot,
  input  logic                 last_of_record,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 push,
  output entry_t               push_entry,
  input  logic                 q_full
);

  localparam int PW = $clog2(KEY_DEPTH);
  localparam int CW = ((PW > CFG_W) ? PW : CFG_W) + 1;
  localparam int SW = (PW > SLOT_W) ? PW : SLOT_W;

  function automatic logic [CFG_W-1:0] eff_len(input logic [CFG_W-1:0] len);
    logic [CFG_W-1:0] r;
    if (len == '0) begin
      r = LEN_RESET;
    end else if (CW'(len) > CW'(KEY_DEPTH)) begin
      r = CFG_W'(KEY_DEPTH);
    end else begin
      r = len;
    end
    return r;
  endfunction

  logic [CFG_W-1:0]  len_a;
  logic [CFG_W-1:0]  len_b;
  logic [PW-1:0]     pos_a;
  logic [PW-1:0]     pos_b;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_data;
  logic              s1_last;
  logic [BYTE_W-1:0] ka;
  logic [BYTE_W-1:0] kb;

  logic              accept;
  logic              is_cipher;
  logic              slot_ok;
  logic [SW-1:0]     slot_ext;
  logic [PW-1:0]     pa;
  logic [PW-1:0]     pb;
  logic [CW-1:0]     pa_inc;
  logic [CW-1:0]     pb_inc;
  logic [PW-1:0]     pos_a_next;
  logic [PW-1:0]     pos_b_next;

  assign in_stall  = s1_valid && q_full;
  assign accept    = in_valid && !in_stall;
  assign is_cipher = (func == FUNC_CIPHER);
  assign slot_ext  = SW'(key_slot);
  assign slot_ok   = (CW'(slot_ext) < CW'(KEY_DEPTH));

  // Use a position at or beyond a lowered length as zero.
  assign pa     = (CW'(pos_a) < CW'(len_a)) ? pos_a : '0;
  assign pb     = (CW'(pos_b) < CW'(len_b)) ? pos_b : '0;
  assign pa_inc = CW'(pa) + CW'(1);
  assign pb_inc = CW'(pb) + CW'(1);

  always_comb begin
    pos_a_next = (pa_inc >= CW'(len_a)) ? '0 : pa_inc[PW-1:0];
    pos_b_next = (pb_inc >= CW'(len_b)) ? '0 : pb_inc[PW-1:0];
    if (last_of_record) begin
      pos_a_next = '0;
      pos_b_next = '0;
    end
  end

  dkx_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_key_a (
    .clk   (clk),
    .we    (accept && (func == FUNC_LOAD_A) && slot_ok),
    .waddr (slot_ext[PW-1:0]),
    .wdata (data_byte),
    .re    (accept && is_cipher),
    .raddr (pa),
    .rdata (ka)
  );

  dkx_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_key_b (
    .clk   (clk),
    .we    (accept && (func == FUNC_LOAD_B) && slot_ok),
    .waddr (slot_ext[PW-1:0]),
    .wdata (data_byte),
    .re    (accept && is_cipher),
    .raddr (pb),
    .rdata (kb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len_a    <= LEN_RESET;
      len_b    <= LEN_RESET;
      pos_a    <= '0;
      pos_b    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == REG_KEY_A_LEN) begin
        len_a <= eff_len(cfg_data);
      end
      if (cfg_write && cfg_index == REG_KEY_B_LEN) begin
        len_b <= eff_len(cfg_data);
      end
      if (accept && is_cipher) begin
        pos_a    <= pos_a_next;
        pos_b    <= pos_b_next;
        s1_valid <= 1'b1;
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_cipher) begin
      s1_data <= data_byte;
      s1_last <= last_of_record;
    end
  end

  assign push            = s1_valid && !q_full;
  assign push_entry.data = s1_data;
  assign push_entry.ka   = ka;
  assign push_entry.kb   = kb;
  assign push_entry.last = s1_last;

  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with no item held in the front stage");

  a_held_item_stable: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && q_full) |=> (s1_valid && $stable(push_entry)))
    else $error("front stage item changed while the queue was full");

endmodule

### src/dkx_queue.sv
// Short queue between the front and back parts.
module dkx_queue import dkx_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t pop_entry
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  entry_t            slots [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(QDEPTH));
  assign q_valid   = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !q_valid))
    else $error("pop from an empty queue");

endmodule

### src/dkx_back.sv
// Back part: applies keys and feedback, holds the result register.
module dkx_back import dkx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  entry_t            q_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] result_byte,
  output logic              last_out
);

  logic [BYTE_W-1:0]   fb;
  logic [2*BYTE_W-1:0] prod;
  logic [BYTE_W-1:0]   fb_next;

  assign pop  = q_valid && (!out_valid || !out_stall);
  assign prod = q_entry.ka * q_entry.kb;

  // Drop the feedback at the end of a record.
  assign fb_next = q_entry.last ? '0 : fb + prod[BYTE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fb        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        fb        <= fb_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_byte <= q_entry.data ^ q_entry.ka ^ q_entry.kb ^ fb;
      last_out    <= q_entry.last;
    end
  end

  a_record_end_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && q_entry.last) |=> (fb == '0))
    else $error("feedback not cleared after the last item of a record");

endmodule

### src/dual_key_xor_feedback_cipher_unit.sv
// Top level of the dual-key XOR feedback cipher.
// A cipher item passes the front stage, the queue and the result register. The key RAM read
// and 8x8 multiply-add take one stage each; one item per cycle unless out_stall or q_full.
// Load items and unused codes produce no result and never stall the back part.
// Reset clears key positions, feedback, the queue and sets both key lengths to one.
// Key RAM contents are not cleared by reset; every entry must be loaded before it is used.
module dual_key_xor_feedback_cipher_unit import dkx_pkg::*; #(
  parameter int KEY_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    func,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic [SLOT_W-1:0]    key_slot,
  input  logic                 last_of_record,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    result_byte,
  output logic                 last_out,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   q_valid;
  entry_t q_entry;

  dkx_front #(.KEY_DEPTH(KEY_DEPTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .data_byte      (data_byte),
    .key_slot       (key_slot),
    .last_of_record (last_of_record),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .push_entry     (push_entry),
    .q_full         (q_full)
  );

  dkx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .pop_entry  (q_entry)
  );

  dkx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_byte (result_byte),
    .last_out    (last_out)
  );

endmodule
